>>> hw/rtl/rdwp_pkg.sv
// Package for the wavetable player: table geometry, request and register codes,
// reset values and datapath widths.
// No dependencies.
package rdwp_pkg;

    localparam int TABLE_DEPTH = 8192;
    localparam int SAMPLE_BITS = 12;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;

    localparam int DIV_W       = 24;
    localparam int DIV_CNT_W   = 5;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RPM   = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        JOB_PERIOD = 2'd0,
        JOB_GAIN   = 2'd1,
        JOB_SCALE  = 2'd2
    } job_t;

    localparam logic [2:0] CFG_TABLE_LENGTH = 3'd0;
    localparam logic [2:0] CFG_CENTER_LEVEL = 3'd1;
    localparam logic [2:0] CFG_RPM_FULL     = 3'd2;
    localparam logic [2:0] CFG_PERIOD_IDLE  = 3'd3;
    localparam logic [2:0] CFG_PERIOD_FULL  = 3'd4;
    localparam logic [2:0] CFG_GAIN_IDLE    = 3'd5;
    localparam logic [2:0] CFG_GAIN_FULL    = 3'd6;

    localparam logic [13:0] RST_TABLE_LENGTH = 14'd5825;
    localparam logic [11:0] RST_CENTER_LEVEL = 12'd512;
    localparam logic [13:0] RST_RPM_FULL     = 14'd6100;
    localparam logic [8:0]  RST_PERIOD_IDLE  = 9'd35;
    localparam logic [8:0]  RST_PERIOD_FULL  = 9'd10;
    localparam logic [10:0] RST_GAIN_IDLE    = 11'd128;
    localparam logic [10:0] RST_GAIN_FULL    = 11'd768;

endpackage

>>> hw/rtl/rpm_driven_wavetable_player.sv
// Engine-sound wavetable player: sample table, rpm-to-period and gain mapping,
// tick counter and scaled sample output, built around one multiplier and one divider.
// Depends on rdwp_pkg.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  tuser: req_type; tdata: table_index, sample_value, rpm
// m_        out        m_tvalid/m_tready  tdata: dac_value, played_index
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// A table write, an unused request or a tick that plays nothing leaves the block idle.
// A tick that plays a sample goes through table read, multiply and output, and waits in output while the output stalls.
// An rpm request makes up to two passes through the 24-step restoring divider.
// A saturated rpm or equal idle and full periods need one pass or none.
// Reset is synchronous and active low; the sample table has no reset.
// The block accepts no request while one is in progress.
module rpm_driven_wavetable_player
    import rdwp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic [39:0] s_tdata,   // [12:0] table_index, [24:13] sample_value, [38:25] rpm
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] dac_value, [24:12] played_index
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ   = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_PREP   = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    logic [SAMPLE_BITS-1:0] sample_mem [TABLE_DEPTH];

    logic [13:0] table_length_reg;
    logic [11:0] center_level_reg;
    logic [13:0] rpm_full_reg;
    logic [8:0]  period_idle_reg;
    logic [8:0]  period_full_reg;
    logic [10:0] gain_idle_reg;
    logic [10:0] gain_full_reg;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic signed [17:0] op_a_reg, op_a_next;
    logic signed [11:0] op_b_reg, op_b_next;
    logic signed [29:0] prod_reg, prod_next;

    logic [13:0]          div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]     div_quo_reg, div_quo_next;
    logic [13:0]          div_den_reg, div_den_next;
    logic                 div_neg_reg, div_neg_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [8:0]        tick_count_reg, tick_count_next;
    logic [8:0]        tick_period_reg, tick_period_next;
    logic [10:0]       gain_reg, gain_next;
    logic [ADDR_W-1:0] read_index_reg, read_index_next;
    logic [12:0]       play_index_reg, play_index_next;
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [11:0] m_dac_reg, m_dac_next;
    logic [12:0] m_index_reg, m_index_next;

    req_t  in_req;
    logic [12:0] in_index;
    logic [11:0] in_sample;
    logic [13:0] in_rpm;
    logic        accept;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [16:0]       in_index_ext;
    logic [15:0]       in_sample_ext;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [LEN_W-1:0] eff_len;
    logic [9:0]       tick_inc;
    logic             tick_play;
    logic [ADDR_W-1:0] play_pos;
    logic [LEN_W-1:0] pos_inc;

    logic signed [9:0]  period_diff;
    logic [8:0]         gain_per;
    logic signed [9:0]  gain_per_off;
    logic signed [11:0] gain_diff;
    logic [29:0]        prod_mag;
    logic [14:0]        div_shift;
    logic               div_ge;
    logic signed [12:0] quo_signed;
    logic signed [12:0] per_sum;
    logic signed [12:0] gain_sum;
    logic [15:0]        raw_ext;
    logic signed [30:0] scale_sum;
    logic [21:0]        scale_shift;
    logic [11:0]        dac_value;

    assign in_req    = req_t'(s_tuser);
    assign in_index  = s_tdata[12:0];
    assign in_sample = s_tdata[24:13];
    assign in_rpm    = s_tdata[38:25];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_index_ext  = {4'b0, in_index};
    assign in_sample_ext = {4'b0, in_sample};
    assign mem_waddr     = in_index_ext[ADDR_W-1:0];

    always_comb begin
        if (table_length_reg == 14'd0) begin
            eff_len = LEN_W'(1);
        end else if (18'(table_length_reg) > 18'(TABLE_DEPTH)) begin
            eff_len = LEN_W'(TABLE_DEPTH);
        end else begin
            eff_len = LEN_W'(table_length_reg);
        end
    end

    assign tick_inc  = {1'b0, tick_count_reg} + 10'd1;
    assign tick_play = (tick_inc >= {1'b0, tick_period_reg});
    assign play_pos  = ({1'b0, read_index_reg} >= eff_len) ? '0 : read_index_reg;
    assign pos_inc   = {1'b0, play_pos} + LEN_W'(1);

    assign period_diff = $signed({1'b0, period_full_reg}) - $signed({1'b0, period_idle_reg});
    assign gain_diff   = $signed({1'b0, gain_full_reg}) - $signed({1'b0, gain_idle_reg});
    assign gain_per_off = $signed({1'b0, gain_per}) - $signed({1'b0, period_idle_reg});

    assign prod_next = op_a_reg * op_b_reg;
    assign prod_mag  = prod_reg[29] ? 30'(-prod_reg) : 30'(prod_reg);

    assign div_shift = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, div_den_reg});

    assign quo_signed = div_neg_reg ? -$signed({1'b0, div_quo_reg[11:0]})
                                    : $signed({1'b0, div_quo_reg[11:0]});
    assign per_sum  = $signed({4'b0, period_idle_reg}) + quo_signed;
    assign gain_sum = $signed({2'b0, gain_idle_reg}) + quo_signed;

    assign raw_ext     = 16'(rd_data_reg);
    assign scale_sum   = $signed({11'b0, center_level_reg, 8'b0}) + {prod_reg[29], prod_reg};
    assign scale_shift = scale_sum[29:8];

    always_comb begin
        if (scale_sum[30]) begin
            dac_value = 12'd0;
        end else if (scale_shift > 22'(SAMPLE_TOP)) begin
            dac_value = 12'(SAMPLE_TOP);
        end else begin
            dac_value = scale_shift[11:0];
        end
    end

    always_comb begin
        state_next       = state_reg;
        job_next         = job_reg;
        op_a_next        = op_a_reg;
        op_b_next        = op_b_reg;
        div_rem_next     = div_rem_reg;
        div_quo_next     = div_quo_reg;
        div_den_next     = div_den_reg;
        div_neg_next     = div_neg_reg;
        div_cnt_next     = div_cnt_reg;
        tick_count_next  = tick_count_reg;
        tick_period_next = tick_period_reg;
        gain_next        = gain_reg;
        read_index_next  = read_index_reg;
        play_index_next  = play_index_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_dac_next       = m_dac_reg;
        m_index_next     = m_index_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = play_pos;
        gain_per         = period_full_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_req)
                        REQ_WRITE: begin
                            mem_we = (int'(in_index) < TABLE_DEPTH);
                        end
                        REQ_RPM: begin
                            if (rpm_full_reg == 14'd0 || in_rpm >= rpm_full_reg) begin
                                tick_period_next = period_full_reg;
                                if (period_full_reg == period_idle_reg) begin
                                    gain_next = gain_idle_reg;
                                end else begin
                                    op_a_next  = 18'(gain_per_off);
                                    op_b_next  = gain_diff;
                                    job_next   = JOB_GAIN;
                                    state_next = ST_MUL;
                                end
                            end else begin
                                op_a_next  = $signed({4'b0, in_rpm});
                                op_b_next  = 12'(period_diff);
                                job_next   = JOB_PERIOD;
                                state_next = ST_MUL;
                            end
                        end
                        REQ_TICK: begin
                            if (tick_play) begin
                                tick_count_next = 9'd0;
                                mem_re          = 1'b1;
                                play_index_next = 13'(play_pos);
                                read_index_next = (pos_inc >= eff_len) ? '0
                                                                       : pos_inc[ADDR_W-1:0];
                                state_next      = ST_READ;
                            end else begin
                                tick_count_next = tick_inc[8:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                op_a_next  = $signed({2'b0, raw_ext}) - $signed({6'b0, center_level_reg});
                op_b_next  = $signed({1'b0, gain_reg});
                job_next   = JOB_SCALE;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = (job_reg == JOB_SCALE) ? ST_OUT : ST_PREP;
            end
            ST_PREP: begin
                div_rem_next = 14'd0;
                div_quo_next = prod_mag[DIV_W-1:0];
                div_cnt_next = DIV_CNT_W'(DIV_W);
                if (job_reg == JOB_PERIOD) begin
                    div_den_next = rpm_full_reg;
                    div_neg_next = prod_reg[29];
                end else begin
                    div_den_next = period_diff[9] ? 14'(-period_diff) : 14'(period_diff);
                    div_neg_next = prod_reg[29] ^ period_diff[9];
                end
                state_next = ST_DIV;
            end
            ST_DIV: begin
                div_rem_next = div_ge ? 14'(div_shift - {1'b0, div_den_reg}) : div_shift[13:0];
                div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (job_reg == JOB_PERIOD) begin
                    gain_per         = per_sum[8:0];
                    tick_period_next = per_sum[8:0];
                    if (period_full_reg == period_idle_reg) begin
                        gain_next  = gain_idle_reg;
                        state_next = ST_IDLE;
                    end else begin
                        op_a_next  = 18'(gain_per_off);
                        op_b_next  = gain_diff;
                        job_next   = JOB_GAIN;
                        state_next = ST_MUL;
                    end
                end else begin
                    gain_next  = gain_sum[10:0];
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_dac_next    = dac_value;
                    m_index_next  = play_index_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sample_mem[mem_waddr] <= in_sample_ext[SAMPLE_BITS-1:0];
        end
        if (mem_re) begin
            rd_data_reg <= sample_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= RST_TABLE_LENGTH;
            center_level_reg <= RST_CENTER_LEVEL;
            rpm_full_reg     <= RST_RPM_FULL;
            period_idle_reg  <= RST_PERIOD_IDLE;
            period_full_reg  <= RST_PERIOD_FULL;
            gain_idle_reg    <= RST_GAIN_IDLE;
            gain_full_reg    <= RST_GAIN_FULL;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TABLE_LENGTH: table_length_reg <= cfg_data;
                CFG_CENTER_LEVEL: center_level_reg <= cfg_data[11:0];
                CFG_RPM_FULL:     rpm_full_reg     <= cfg_data;
                CFG_PERIOD_IDLE:  period_idle_reg  <= cfg_data[8:0];
                CFG_PERIOD_FULL:  period_full_reg  <= cfg_data[8:0];
                CFG_GAIN_IDLE:    gain_idle_reg    <= cfg_data[10:0];
                CFG_GAIN_FULL:    gain_full_reg    <= cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            job_reg         <= JOB_PERIOD;
            div_cnt_reg     <= '0;
            tick_count_reg  <= 9'd0;
            tick_period_reg <= RST_PERIOD_IDLE;
            gain_reg        <= RST_GAIN_IDLE;
            read_index_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            job_reg         <= job_next;
            div_cnt_reg     <= div_cnt_next;
            tick_count_reg  <= tick_count_next;
            tick_period_reg <= tick_period_next;
            gain_reg        <= gain_next;
            read_index_reg  <= read_index_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_a_reg       <= op_a_next;
        op_b_reg       <= op_b_next;
        prod_reg       <= prod_next;
        div_rem_reg    <= div_rem_next;
        div_quo_reg    <= div_quo_next;
        div_den_reg    <= div_den_next;
        div_neg_reg    <= div_neg_next;
        play_index_reg <= play_index_next;
        m_dac_reg      <= m_dac_next;
        m_index_reg    <= m_index_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_index_reg, m_dac_reg};

`ifndef SYNTH
    a_period_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && job_reg == JOB_PERIOD) |->
        ((tick_period_next >= period_idle_reg && tick_period_next <= period_full_reg) ||
         (tick_period_next <= period_idle_reg && tick_period_next >= period_full_reg)))
        else $error("Mapped period lies outside the configured period range.");

    a_gain_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && job_reg == JOB_GAIN) |->
        ((gain_next >= gain_idle_reg && gain_next <= gain_full_reg) ||
         (gain_next <= gain_idle_reg && gain_next >= gain_full_reg)))
        else $error("Mapped gain lies outside the configured gain range.");

    a_play_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_req == REQ_TICK && tick_play) |=>
        (state_reg == ST_READ && tick_count_reg == 9'd0))
        else $error("A due sample did not start a table read.");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("Result became valid outside the output step.");
`endif

endmodule

>>> tb/rpm_driven_wavetable_player_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the engine-sound wavetable player: drives table writes, rpm
// updates and ticks, predicts every played sample and checks the output stream.
// Depends on rdwp_pkg and rpm_driven_wavetable_player.
module rpm_driven_wavetable_player_tb;
    import rdwp_pkg::*;

    typedef struct packed {
        logic [11:0] dac;
        logic [12:0] idx;
    } dac_sample_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = REQ_NONE;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = CFG_TABLE_LENGTH;
    logic [13:0] cfg_data  = '0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int mismatch_count = 0;

    // Predicted player state and registers.
    logic [11:0] table_mem [TABLE_DEPTH];
    bit          written   [TABLE_DEPTH];
    logic [13:0] table_length = RST_TABLE_LENGTH;
    logic [11:0] center_level = RST_CENTER_LEVEL;
    logic [13:0] rpm_full     = RST_RPM_FULL;
    logic [8:0]  period_idle  = RST_PERIOD_IDLE;
    logic [8:0]  period_full  = RST_PERIOD_FULL;
    logic [10:0] gain_idle    = RST_GAIN_IDLE;
    logic [10:0] gain_full    = RST_GAIN_FULL;
    logic [12:0] read_pos     = '0;
    logic [8:0]  tick_count   = '0;
    logic [8:0]  cur_period   = RST_PERIOD_IDLE;
    logic [10:0] cur_gain     = RST_GAIN_IDLE;

    dac_sample_t expected_samples[$];

    rpm_driven_wavetable_player u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL rpm_driven_wavetable_player");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int play_length();
        int n;
        n = table_length;
        if (n == 0) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n;
    endfunction

    function automatic void apply_speed(input logic [13:0] rpm);
        int p_lo, p_hi, g_lo, g_hi, per, g, r, rf;
        p_lo = period_idle;
        p_hi = period_full;
        g_lo = gain_idle;
        g_hi = gain_full;
        r    = rpm;
        rf   = rpm_full;
        if (rf == 0 || r >= rf) per = p_hi;
        else per = p_lo + (r * (p_hi - p_lo)) / rf;
        cur_period = per[8:0];
        if (p_hi == p_lo) begin
            cur_gain = gain_idle;
        end else begin
            g = g_lo + ((per - p_lo) * (g_hi - g_lo)) / (p_hi - p_lo);
            cur_gain = g[10:0];
        end
    endfunction

    function automatic logic [11:0] scaled_level(input logic [11:0] raw);
        int c, t, v, rv, gv;
        c  = center_level;
        rv = raw;
        gv = cur_gain;
        t  = c * 256 + (rv - c) * gv;
        if (t < 0) return 12'd0;
        v = t / 256;
        if (v > SAMPLE_TOP) v = SAMPLE_TOP;
        return v[11:0];
    endfunction

    // Entry that the next tick would play, or -1 when it only counts.
    function automatic int due_entry();
        int nxt, per;
        nxt = tick_count;
        nxt = nxt + 1;
        per = cur_period;
        if (nxt < per) return -1;
        return (read_pos >= play_length()) ? 0 : int'(read_pos);
    endfunction

    function automatic void predict_player(input req_t kind, input logic [12:0] idx,
                                           input logic [11:0] val, input logic [13:0] rpm);
        int pos;
        dac_sample_t s;
        case (kind)
            REQ_WRITE: begin
                table_mem[idx] = val;
                written[idx]   = 1'b1;
            end
            REQ_RPM: begin
                apply_speed(rpm);
            end
            REQ_TICK: begin
                pos = due_entry();
                if (pos < 0) begin
                    tick_count = tick_count + 9'd1;
                end else begin
                    tick_count = '0;
                    s.dac = scaled_level(table_mem[pos]);
                    s.idx = pos[12:0];
                    expected_samples.push_back(s);
                    pos = pos + 1;
                    if (pos >= play_length()) pos = 0;
                    read_pos = pos[12:0];
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what, input dac_sample_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected dac %0d index %0d, got dac %0d index %0d", $realtime,
                     what, want.dac, want.idx, m_tdata[11:0], m_tdata[24:12]);
    endtask

    always @(posedge aclk) begin
        dac_sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                want = '0;
                note_mismatch("sample with none outstanding", want);
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata[11:0] !== want.dac) note_mismatch("dac_value mismatch", want);
                if (m_tdata[24:12] !== want.idx) note_mismatch("played_index mismatch", want);
            end
        end
    end

    task automatic send_req(input req_t kind, input logic [12:0] idx, input logic [11:0] val,
                            input logic [13:0] rpm);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, rpm, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_player(kind, idx, val, rpm);
    endtask

    // A tick that is due to play an entry never written gets that entry written first.
    task automatic send_tick();
        int pos;
        pos = due_entry();
        if (pos >= 0 && !written[pos])
            send_req(REQ_WRITE, pos[12:0], 12'($urandom_range(4095)), 14'($urandom));
        send_req(REQ_TICK, 13'($urandom), 12'($urandom), 14'($urandom));
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_tick();
    endtask

    task automatic send_rpm(input int rpm);
        send_req(REQ_RPM, 13'($urandom), 12'($urandom), rpm[13:0]);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[13:0];
        @(posedge aclk);
    endtask

    task automatic load_config(input int len, input int ctr, input int rfull, input int pidle,
                               input int pfull, input int gidle, input int gfull);
        drain();
        write_reg(CFG_TABLE_LENGTH, len);
        write_reg(CFG_CENTER_LEVEL, ctr);
        write_reg(CFG_RPM_FULL, rfull);
        write_reg(CFG_PERIOD_IDLE, pidle);
        write_reg(CFG_PERIOD_FULL, pfull);
        write_reg(CFG_GAIN_IDLE, gidle);
        write_reg(CFG_GAIN_FULL, gfull);
        @(negedge aclk);
        cfg_we <= 1'b0;
        table_length = len[13:0];
        center_level = ctr[11:0];
        rpm_full     = rfull[13:0];
        period_idle  = pidle[8:0];
        period_full  = pfull[8:0];
        gain_idle    = gidle[10:0];
        gain_full    = gfull[10:0];
    endtask

    task automatic test_defaults();
        send_req(REQ_WRITE, 13'd0, 12'd4095, 14'd0);
        send_req(REQ_WRITE, 13'd1, 12'd0, 14'h3FFF);
        send_req(REQ_WRITE, 13'd2, 12'd2048, 14'd0);
        send_req(REQ_WRITE, 13'd8191, 12'd4095, 14'h3FFF);
        send_req(REQ_NONE, 13'h1FFF, 12'hFFF, 14'h3FFF);
        send_rpm(0);
        run_ticks(35);
        send_rpm(16383);
        run_ticks(10);
        send_rpm(6100);
        run_ticks(10);
    endtask

    task automatic test_config_extremes();
        load_config(0, 0, 0, 0, 0, 0, 0);
        send_rpm(5000);
        run_ticks(3);
        load_config(16383, 4095, 16383, 511, 1, 2047, 0);
        send_rpm(16383);
        run_ticks(4);
        send_rpm(16000);
        run_ticks(14);
        load_config(8192, 2048, 1, 1, 511, 0, 2047);
        send_rpm(0);
        run_ticks(3);
        load_config(3, 100, 100, 4, 4, 300, 2047);
        send_rpm(50);
        run_ticks(12);
        load_config(1, 4095, 16383, 2, 0, 2047, 2047);
        send_rpm(16383);
        run_ticks(4);
    endtask

    task automatic test_period_lowered();
        load_config(16, 1000, 100, 40, 2, 256, 512);
        send_rpm(0);
        run_ticks(20);
        send_rpm(100);
        run_ticks(3);
    endtask

    task automatic test_wrap_and_shorten();
        load_config(8, 2000, 1000, 1, 1, 256, 256);
        send_rpm(500);
        run_ticks(10);
        while (read_pos != 13'd6) send_tick();
        load_config(3, 2000, 1000, 1, 1, 256, 256);
        run_ticks(4);
    endtask

    task automatic random_config();
        int len, rfull, pidle, pfull;
        len   = ($urandom_range(5) == 0) ? $urandom_range(16383) : $urandom_range(1, 64);
        rfull = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 16383);
        pidle = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(12);
        pfull = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(8);
        load_config(len, $urandom_range(4095), rfull, pidle, pfull,
                    $urandom_range(2047), $urandom_range(2047));
        send_rpm($urandom_range(16383));
    endtask

    task automatic random_request();
        int r, idx, val, rpm;
        r = $urandom_range(99);
        if (r < 18) begin
            idx = ($urandom_range(2) == 0) ? $urandom_range(8191)
                                           : $urandom_range(play_length() - 1);
            case ($urandom_range(7))
                0: val = 0;
                1: val = 4095;
                default: val = $urandom_range(4095);
            endcase
            send_req(REQ_WRITE, idx[12:0], val[11:0], 14'($urandom));
        end else if (r < 26) begin
            case ($urandom_range(9))
                0: rpm = 0;
                1: rpm = 16383;
                2: rpm = rpm_full;
                default: rpm = $urandom_range(16383);
            endcase
            send_rpm(rpm);
        end else if (r < 30) begin
            send_req(REQ_NONE, 13'($urandom), 12'($urandom), 14'($urandom));
        end else begin
            send_tick();
        end
    endtask

    task automatic test_random();
        int idle_tbl[4]  = '{0, 58, 0, 13};
        int stall_tbl[4] = '{0, 0, 58, 13};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tbl[ph];
            stall_pct = stall_tbl[ph];
            for (int blk = 0; blk < 2; blk++) begin
                random_config();
                repeat (60) random_request();
                drain();
                repeat (65) random_request();
            end
        end
    endtask

    initial begin
        idle_pct  = 13;
        stall_pct = 13;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_config_extremes();
        test_period_lowered();
        test_wrap_and_shorten();
        test_random();
        drain();
        if (mismatch_count == 0) begin
            $display("PASS rpm_driven_wavetable_player");
        end else begin
            $display("FAIL rpm_driven_wavetable_player");
        end
        $finish;
    end

endmodule
